// ----- sv/fat12_pkg.sv -----
`timescale 1ns / 1ps

package fat12_pkg;

    // Table store geometry. The store is split into an even-byte bank and an
    // odd-byte bank so that one 12-bit entry is fetched in a single access.
    localparam int TABLE_BYTES = 8192;
    localparam int TBL_AW      = $clog2(TABLE_BYTES);
    localparam int BANK_AW     = TBL_AW - 1;
    localparam int BANK_DEPTH  = TABLE_BYTES / 2;

    localparam logic [11:0] END_MARK    = 12'hFF8;
    localparam logic [11:0] CLUSTER_MIN = 12'd2;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_CHAIN    = 2'd1;
    localparam logic [1:0] STATUS_LOW_CLUSTER = 2'd2;

    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_SECTORS    = 1'b1;

    typedef struct packed {
        logic        en;
        logic [12:0] addr;
        logic [7:0]  data;
    } tbl_wr_t;

    typedef struct packed {
        logic        en;
        logic [11:0] cluster;
    } tbl_rd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NEXT,
        ST_LAST
    } state_t;

endpackage

// ----- sv/fat12_table.sv -----
`timescale 1ns / 1ps

module fat12_table
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fat12_pkg::tbl_wr_t   wr,
    input  fat12_pkg::tbl_rd_t   rd,
    output logic [11:0]          entry
);

    logic [7:0] even_mem [fat12_pkg::BANK_DEPTH];
    logic [7:0] odd_mem  [fat12_pkg::BANK_DEPTH];

    logic [12:0] idx;
    logic [13:0] idx_hi;
    logic        lo_ok;
    logic        hi_ok;
    logic        wr_ok;

    logic [7:0]  even_q;
    logic [7:0]  odd_q;
    logic        swap_q;
    logic        shift_q;
    logic        lo_ok_q;
    logic        hi_ok_q;

    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [15:0] word;

    // The entry of cluster c starts at byte c + c/2 and spans two bytes.
    assign idx    = 13'({1'b0, rd.cluster}) + 13'({2'b00, rd.cluster[11:1]});
    assign idx_hi = 14'(idx) + 14'd1;
    assign lo_ok  = 14'(idx) < 14'(fat12_pkg::TABLE_BYTES);
    assign hi_ok  = idx_hi < 14'(fat12_pkg::TABLE_BYTES);
    assign wr_ok  = wr.en && (14'(wr.addr) < 14'(fat12_pkg::TABLE_BYTES));

    always_ff @(posedge clk)
    begin
        if (wr_ok && !wr.addr[0])
        begin
            even_mem[wr.addr[fat12_pkg::BANK_AW:1]] <= wr.data;
        end
        if (wr_ok && wr.addr[0])
        begin
            odd_mem[wr.addr[fat12_pkg::BANK_AW:1]] <= wr.data;
        end
        if (rd.en)
        begin
            even_q <= even_mem[idx_hi[fat12_pkg::BANK_AW:1]];
            odd_q  <= odd_mem[idx[fat12_pkg::BANK_AW:1]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_q  <= 1'b0;
            shift_q <= 1'b0;
            lo_ok_q <= 1'b0;
            hi_ok_q <= 1'b0;
        end
        else if (rd.en)
        begin
            swap_q  <= idx[0];
            shift_q <= rd.cluster[0];
            lo_ok_q <= lo_ok;
            hi_ok_q <= hi_ok;
        end
    end

    always_comb
    begin
        lo_byte = swap_q ? odd_q : even_q;
        hi_byte = swap_q ? even_q : odd_q;
        word    = {hi_ok_q ? hi_byte : 8'h00, lo_ok_q ? lo_byte : 8'h00};
        entry   = shift_q ? word[15:4] : word[11:0];
    end

endmodule

// ----- sv/fat12_cluster_chain_walker.sv -----
`timescale 1ns / 1ps

// FAT12 cluster chain walker.
// Input channel (in_valid / in_stall) carries one transaction per command:
// kind 0 writes table_byte at table_addr of the allocation table, kind 1
// starts a chain at start_cluster, kind 2 advances the chain. Kind 3 is
// ignored. Kinds 1 and 2 each produce one result transaction on the output
// channel (out_valid / out_stall) with the cluster, its first sector
// (data_start_lba + (cluster - 2) * sectors_per_cluster), a last flag and a
// status. Configuration is written through cfg_we / cfg_index / cfg_data;
// the user must do so only while the block is idle, which the block itself
// does not enforce. A table write completes in the idle state. A start
// reads the start cluster's entry, then loads the output register. An
// advance reads the current cluster's entry, then the new cluster's own
// entry to find the last flag, then loads; with no chain active it skips
// both reads. Table reads are registered. One command is in flight at a time.
// Reset clears chain state, out_valid and configuration (data start 0, one
// sector per cluster); result payload and table memory are not cleared.
// When the receiver stalls, the result holds in the output register and a
// finished step waits for the slot, which holds off the next command.

module fat12_cluster_chain_walker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [12:0] table_addr,
    input  logic [7:0]  table_byte,
    input  logic [11:0] start_cluster,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] cluster,
    output logic [20:0] sector,
    output logic        last,
    output logic [1:0]  status
);

    fat12_pkg::state_t  state_reg, state_next;
    logic [11:0]        cand_reg, cand_next;
    logic               no_chain_reg, no_chain_next;
    logic [11:0]        current_reg, current_next;
    logic               active_reg, active_next;

    logic [19:0]        dstart_reg;
    logic [7:0]         spc_reg;

    logic               out_valid_reg, out_valid_next;
    logic [11:0]        cluster_reg, cluster_next;
    logic [20:0]        sector_reg, sector_next;
    logic               last_reg, last_next;
    logic [1:0]         status_reg, status_next;

    fat12_pkg::tbl_wr_t wr;
    fat12_pkg::tbl_rd_t rd;
    logic [11:0]        entry;

    logic               in_take;
    logic               slot_free;
    logic               load;
    logic               is_last;
    logic [11:0]        offs;
    logic [19:0]        prod;
    logic [20:0]        sector_calc;

    // The table has one write and one read port. Only one command is in
    // flight at a time, so a write never meets a read of the same entry.
    fat12_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .entry (entry)
    );

    assign in_stall  = (state_reg != fat12_pkg::ST_IDLE);
    assign in_take   = in_valid && (state_reg == fat12_pkg::ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    // Sector of the candidate cluster: one 12x8 multiply and one add.
    assign offs        = cand_reg - fat12_pkg::CLUSTER_MIN;
    assign prod        = {8'd0, offs} * {12'd0, spc_reg};
    assign sector_calc = 21'(dstart_reg) + 21'(prod);
    assign is_last     = (entry >= fat12_pkg::END_MARK);

    always_comb
    begin
        state_next    = state_reg;
        cand_next     = cand_reg;
        no_chain_next = no_chain_reg;
        current_next  = current_reg;
        active_next   = active_reg;
        wr            = '0;
        rd            = '0;
        load          = 1'b0;
        cluster_next  = '0;
        sector_next   = '0;
        last_next     = 1'b0;
        status_next   = fat12_pkg::STATUS_OK;

        case (state_reg)
            fat12_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    case (kind)
                        fat12_pkg::KIND_WRITE:
                        begin
                            wr.en   = 1'b1;
                            wr.addr = table_addr;
                            wr.data = table_byte;
                        end
                        fat12_pkg::KIND_START:
                        begin
                            cand_next     = start_cluster;
                            no_chain_next = 1'b0;
                            rd.en         = 1'b1;
                            rd.cluster    = start_cluster;
                            state_next    = fat12_pkg::ST_LAST;
                        end
                        fat12_pkg::KIND_ADVANCE:
                        begin
                            if (active_reg)
                            begin
                                rd.en      = 1'b1;
                                rd.cluster = current_reg;
                                state_next = fat12_pkg::ST_NEXT;
                            end
                            else
                            begin
                                cand_next     = '0;
                                no_chain_next = 1'b1;
                                state_next    = fat12_pkg::ST_LAST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // The entry of the current cluster is the next cluster; fetch
            // that cluster's own entry to learn whether it ends the chain.
            fat12_pkg::ST_NEXT:
            begin
                cand_next     = entry;
                no_chain_next = 1'b0;
                rd.en         = 1'b1;
                rd.cluster    = entry;
                state_next    = fat12_pkg::ST_LAST;
            end

            // Finish the step once the output register can take it; the
            // table read data holds while we wait.
            fat12_pkg::ST_LAST:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = fat12_pkg::ST_IDLE;
                    if (no_chain_reg)
                    begin
                        status_next = fat12_pkg::STATUS_NO_CHAIN;
                    end
                    else if (cand_reg < fat12_pkg::CLUSTER_MIN)
                    begin
                        current_next = cand_reg;
                        active_next  = 1'b0;
                        cluster_next = cand_reg;
                        status_next  = fat12_pkg::STATUS_LOW_CLUSTER;
                    end
                    else
                    begin
                        current_next = cand_reg;
                        active_next  = !is_last;
                        cluster_next = cand_reg;
                        sector_next  = sector_calc;
                        last_next    = is_last;
                    end
                end
            end

            default:
            begin
                state_next = fat12_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fat12_pkg::ST_IDLE;
            no_chain_reg  <= 1'b0;
            current_reg   <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            dstart_reg    <= '0;
            spc_reg       <= 8'd1;
        end
        else
        begin
            state_reg     <= state_next;
            no_chain_reg  <= no_chain_next;
            current_reg   <= current_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fat12_pkg::CFG_DATA_START: dstart_reg <= cfg_data;
                    fat12_pkg::CFG_SECTORS:    spc_reg    <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        if (load)
        begin
            cluster_reg <= cluster_next;
            sector_reg  <= sector_next;
            last_reg    <= last_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cluster   = cluster_reg;
    assign sector    = sector_reg;
    assign last      = last_reg;
    assign status    = status_reg;

endmodule

// ----- sv/fat12_cluster_chain_walker_chk.sv -----
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  kind,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] cluster,
    input logic [20:0] sector,
    input logic        last,
    input logic [1:0]  status
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cluster) && $stable(sector)
            && $stable(last) && $stable(status))
        else $error("stalled result changed");

    // An advance with no chain reports all-zero fields.
    a_no_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fat12_pkg::STATUS_NO_CHAIN)
            |-> (cluster == 12'd0) && (sector == 21'd0) && !last)
        else $error("no-chain result has nonzero fields");

    // A low-cluster result names cluster 0 or 1 with no sector and no last.
    a_low_cluster: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fat12_pkg::STATUS_LOW_CLUSTER)
            |-> (cluster < fat12_pkg::CLUSTER_MIN) && (sector == 21'd0) && !last)
        else $error("low-cluster result malformed");

    // A normal step always names a data cluster.
    a_ok_cluster: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fat12_pkg::STATUS_OK) |-> (cluster >= fat12_pkg::CLUSTER_MIN))
        else $error("ok result with cluster below 2");

    // A chain command occupies the block for at least the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall
            && ((kind == fat12_pkg::KIND_START) || (kind == fat12_pkg::KIND_ADVANCE))
            |=> in_stall)
        else $error("chain command did not hold off input");

endmodule

bind fat12_cluster_chain_walker fat12_cluster_chain_walker_chk u_chk (.*);
